/* hw/rtl/pid_hdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_hdc_pkg - shared types and microcode for the PID heater duty controller
// Holds the control word layout, the step program and the register map.
// ----------------------------------------------------------------------------
package pid_hdc_pkg;

  // register map, index = paddr / 4
  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_KP     = 3'd1;
  localparam logic [2:0] REG_KI     = 3'd2;
  localparam logic [2:0] REG_KD     = 3'd3;
  localparam logic [2:0] REG_IMAX   = 3'd4;
  localparam logic [2:0] REG_IMIN   = 3'd5;
  localparam logic [2:0] REG_SCALE  = 3'd6;

  // program addresses
  localparam logic [3:0] STEP_IDLE     = 4'd0;
  localparam logic [3:0] STEP_MUL_TEMP = 4'd1;
  localparam logic [3:0] STEP_TEMP     = 4'd2;
  localparam logic [3:0] STEP_ERR      = 4'd3;
  localparam logic [3:0] STEP_INT      = 4'd4;
  localparam logic [3:0] STEP_ACC_P    = 4'd5;
  localparam logic [3:0] STEP_ACC_I    = 4'd6;
  localparam logic [3:0] STEP_ACC_D    = 4'd7;
  localparam logic [3:0] STEP_EMIT     = 4'd8;

  typedef enum logic [1:0] {
    MUL_SCALE,
    MUL_KP,
    MUL_KI,
    MUL_KD
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_IN,
    COND_OUT
  } cond_t;

  typedef struct packed {
    logic       take_in;
    mul_sel_t   mul_sel;
    logic       ld_temp;
    logic       ld_err;
    logic       ld_int;
    acc_op_t    acc_op;
    logic       emit;
    cond_t      cond;
    logic [3:0] nxt;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [3:0] step);
    ctrl_t w;
    w = '{take_in: 1'b0, mul_sel: MUL_SCALE, ld_temp: 1'b0, ld_err: 1'b0, ld_int: 1'b0,
          acc_op: ACC_HOLD, emit: 1'b0, cond: COND_NONE, nxt: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = COND_IN;
        w.nxt     = STEP_MUL_TEMP;
      end
      STEP_MUL_TEMP: begin
        w.mul_sel = MUL_SCALE;
        w.nxt     = STEP_TEMP;
      end
      STEP_TEMP: begin
        w.ld_temp = 1'b1;
        w.nxt     = STEP_ERR;
      end
      STEP_ERR: begin
        w.ld_err = 1'b1;
        w.nxt    = STEP_INT;
      end
      STEP_INT: begin
        w.ld_int  = 1'b1;
        w.mul_sel = MUL_KP;
        w.nxt     = STEP_ACC_P;
      end
      STEP_ACC_P: begin
        w.acc_op  = ACC_LOAD;
        w.mul_sel = MUL_KI;
        w.nxt     = STEP_ACC_I;
      end
      STEP_ACC_I: begin
        w.acc_op  = ACC_ADD;
        w.mul_sel = MUL_KD;
        w.nxt     = STEP_ACC_D;
      end
      STEP_ACC_D: begin
        w.acc_op = ACC_SUB;
        w.nxt    = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_OUT;
        w.nxt  = STEP_IDLE;
      end
      default: begin
        w.nxt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/pid_heater_duty_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_heater_duty_controller_unit - PID heater duty controller
// Scales a raw sensor word to Q8.8, runs a clamped-integral PID with derivative
// on measurement and delivers an inverted PWM duty with the temperature.
// ----------------------------------------------------------------------------
// Each sample takes one accept step and eight microcode steps that share a
// single 25x21 signed multiplier (sensor scaling, then Kp, Ki and Kd products
// accumulated in turn); the result is registered at the last step. A new
// sample is taken once the program is back at its idle step; the finished
// result sits in an output register, so the next sample may enter while it
// waits. The last step holds only when that register is still full.
module pid_heater_duty_controller_unit #(
  parameter int PERIOD = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] raw_reading
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [9:0] duty, [25:10] temperature, [31:26] zero
);

  localparam logic [15:0] PERIOD_W = 16'(PERIOD);
  localparam logic [29:0] PERIOD_Q = 30'(PERIOD);

  pid_hdc_pkg::ctrl_t ctrl;

  logic [3:0]         step_r, step_nxt;
  logic signed [15:0] target_r;
  logic [19:0]        kp_r, ki_r, kd_r;
  logic signed [23:0] imax_r, imin_r;
  logic [15:0]        scale_r;

  logic signed [11:0] count_r;
  logic signed [45:0] prod_r;
  logic signed [15:0] temp_r, prev_r;
  logic signed [16:0] err_r, dtemp_r;
  logic signed [23:0] int_r;
  logic signed [45:0] acc_r;
  logic               out_valid_r;
  logic [9:0]         out_duty_r;
  logic signed [15:0] out_temp_r;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic               in_xfer, slot_free, go;
  logic signed [24:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [45:0] prod_nxt;
  logic               temp_fits;
  logic signed [15:0] temp_nxt;
  logic signed [16:0] temp_ext, target_ext, prev_ext, err_nxt, dtemp_nxt;
  logic signed [24:0] sum, int_ext, err_ext, imax_ext, imin_ext;
  logic signed [23:0] int_nxt;
  logic [29:0]        acc_q;
  logic [15:0]        drive, duty_full;

  assign ctrl = pid_hdc_pkg::ucode(step_r);

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      kp_r     <= 20'd25600;
      ki_r     <= 20'd512;
      kd_r     <= 20'd2560;
      imax_r   <= 24'sd255744;
      imin_r   <= '0;
      scale_r  <= 16'd4116;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pid_hdc_pkg::REG_TARGET: target_r <= cfg_pwdata[15:0];
        pid_hdc_pkg::REG_KP:     kp_r     <= cfg_pwdata[19:0];
        pid_hdc_pkg::REG_KI:     ki_r     <= cfg_pwdata[19:0];
        pid_hdc_pkg::REG_KD:     kd_r     <= cfg_pwdata[19:0];
        pid_hdc_pkg::REG_IMAX:   imax_r   <= cfg_pwdata[23:0];
        pid_hdc_pkg::REG_IMIN:   imin_r   <= cfg_pwdata[23:0];
        pid_hdc_pkg::REG_SCALE:  scale_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pid_hdc_pkg::REG_TARGET: cfg_prdata = {{16{target_r[15]}}, target_r};
      pid_hdc_pkg::REG_KP:     cfg_prdata = {12'd0, kp_r};
      pid_hdc_pkg::REG_KI:     cfg_prdata = {12'd0, ki_r};
      pid_hdc_pkg::REG_KD:     cfg_prdata = {12'd0, kd_r};
      pid_hdc_pkg::REG_IMAX:   cfg_prdata = {{8{imax_r[23]}}, imax_r};
      pid_hdc_pkg::REG_IMIN:   cfg_prdata = {{8{imin_r[23]}}, imin_r};
      pid_hdc_pkg::REG_SCALE:  cfg_prdata = {16'd0, scale_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // sequencer
  assign in_tready = ctrl.take_in;
  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    unique case (ctrl.cond)
      pid_hdc_pkg::COND_IN:  go = in_xfer;
      pid_hdc_pkg::COND_OUT: go = slot_free;
      default:               go = 1'b1;
    endcase
    step_nxt = go ? ctrl.nxt : step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pid_hdc_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // shared multiplier
  always_comb begin
    unique case (ctrl.mul_sel)
      pid_hdc_pkg::MUL_KP: begin
        mul_a = $signed({{8{err_r[16]}}, err_r});
        mul_b = $signed({1'b0, kp_r});
      end
      pid_hdc_pkg::MUL_KI: begin
        mul_a = $signed({int_r[23], int_r});
        mul_b = $signed({1'b0, ki_r});
      end
      pid_hdc_pkg::MUL_KD: begin
        mul_a = $signed({{8{dtemp_r[16]}}, dtemp_r});
        mul_b = $signed({1'b0, kd_r});
      end
      default: begin
        mul_a = $signed({{13{count_r[11]}}, count_r});
        mul_b = $signed({5'd0, scale_r});
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // temperature: floor(product / 256), saturated to Q8.8
  assign temp_fits = (&prod_r[45:23]) || !(|prod_r[45:23]);
  assign temp_nxt  = temp_fits ? $signed(prod_r[23:8]) :
                     (prod_r[45] ? 16'sh8000 : 16'sh7fff);

  assign temp_ext   = $signed({temp_r[15], temp_r});
  assign target_ext = $signed({target_r[15], target_r});
  assign prev_ext   = $signed({prev_r[15], prev_r});
  assign err_nxt    = target_ext - temp_ext;
  assign dtemp_nxt  = temp_ext - prev_ext;

  // integral with clamp, upper bound first
  assign int_ext  = $signed({int_r[23], int_r});
  assign err_ext  = $signed({{8{err_r[16]}}, err_r});
  assign imax_ext = $signed({imax_r[23], imax_r});
  assign imin_ext = $signed({imin_r[23], imin_r});
  assign sum      = int_ext + err_ext;

  always_comb begin
    priority if (sum > imax_ext) begin
      int_nxt = imax_r;
    end else if (sum < imin_ext) begin
      int_nxt = imin_r;
    end else begin
      int_nxt = sum[23:0];
    end
  end

  // drive: negative gives zero, otherwise clamp to PERIOD
  assign acc_q = acc_r[45:16];

  always_comb begin
    priority if (acc_r[45]) begin
      drive = '0;
    end else if (acc_q > PERIOD_Q) begin
      drive = PERIOD_W;
    end else begin
      drive = acc_q[15:0];
    end
    duty_full = PERIOD_W - drive;
    if (target_r[15] || target_r == 16'sd0) begin
      duty_full = PERIOD_W;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (in_xfer) begin
      count_r <= $signed(in_tdata[15:4]);
    end
    if (ctrl.ld_temp) begin
      temp_r <= temp_nxt;
    end
    if (ctrl.ld_err) begin
      err_r   <= err_nxt;
      dtemp_r <= dtemp_nxt;
    end
    unique case (ctrl.acc_op)
      pid_hdc_pkg::ACC_LOAD: acc_r <= prod_r;
      pid_hdc_pkg::ACC_ADD:  acc_r <= acc_r + prod_r;
      pid_hdc_pkg::ACC_SUB:  acc_r <= acc_r - prod_r;
      default: ;
    endcase
    if (ctrl.emit && slot_free) begin
      out_duty_r <= duty_full[9:0];
      out_temp_r <= temp_r;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r  <= '0;
      prev_r <= '0;
    end else begin
      if (ctrl.ld_int) begin
        int_r <= int_nxt;
      end
      if (ctrl.ld_err) begin
        prev_r <= temp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_temp_r, out_duty_r};

  // checks
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> step_r == pid_hdc_pkg::STEP_MUL_TEMP)
    else $error("program did not start after input transfer");

  a_int_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ld_int |=> (imin_r > imax_r) || (int_r <= imax_r && int_r >= imin_r))
    else $error("integral outside its bounds");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(step_r == pid_hdc_pkg::STEP_EMIT))
    else $error("result appeared outside the emit step");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == pid_hdc_pkg::STEP_EMIT && out_valid_r && !out_tready)
      |=> step_r == pid_hdc_pkg::STEP_EMIT)
    else $error("emit step left while output register full");

endmodule
